/* rtl/core/array_list_insert_search_tally_core_defines.svh */
// ----------------------------------------------------------------------------
// array list insert/search/tally core: assertion macros
// used by the checker file that binds onto the core
// ----------------------------------------------------------------------------
`ifndef ARRAY_LIST_INSERT_SEARCH_TALLY_CORE_DEFINES_SVH
`define ARRAY_LIST_INSERT_SEARCH_TALLY_CORE_DEFINES_SVH

// checked only while out of reset
`define ALIST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked also through reset
`define ALIST_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/alist_pkg.sv */
// ----------------------------------------------------------------------------
// alist_pkg
// types, codes and helpers of the array list insert/search/tally core
// ----------------------------------------------------------------------------
`default_nettype none

package alist_pkg;

  localparam int NAME_BYTES = 20;
  localparam int NAME_W     = 8 * NAME_BYTES;

  // item kinds
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_FIND   = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  // categories
  localparam logic [1:0] CAT_PERENNIAL = 2'd0;
  localparam logic [1:0] CAT_ANNUAL    = 2'd1;
  localparam logic [1:0] CAT_BIENNIAL  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BAD_POS  = 3'd2;
  localparam logic [2:0] ST_MATCH    = 3'd3;
  localparam logic [2:0] ST_NO_MATCH = 3'd4;
  localparam logic [2:0] ST_TOTALS   = 3'd5;

  localparam logic [5:0]  RESULT_LIMIT = 6'd32;
  localparam logic [20:0] TOTAL_MAX    = 21'h1F_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  position;
    logic [63:0] name_high;
    logic [63:0] name_mid;
    logic [31:0] name_low;
    logic [1:0]  category;
    logic [15:0] quantity;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  found_position;
    logic [1:0]  found_category;
    logic [15:0] found_quantity;
    logic [20:0] total_perennial;
    logic [20:0] total_annual;
    logic [20:0] total_biennial;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [1:0]        category;
    logic [15:0]       quantity;
  } record_t;

  // clear every byte after the first zero byte
  function automatic logic [NAME_W-1:0] name_canon(input logic [NAME_W-1:0] n);
    logic              ended;
    logic [NAME_W-1:0] r;
    ended = 1'b0;
    r     = n;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (ended) begin
        r[NAME_W-1-8*i -: 8] = 8'h00;
      end else if (n[NAME_W-1-8*i -: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/array_list_insert_search_tally_core.sv */
// ----------------------------------------------------------------------------
// array_list_insert_search_tally_core
// ordered record list in one synchronous memory: positional insert with
// shift, find by name, per-category quantity totals
// ----------------------------------------------------------------------------
//
//   channel | direction | payload    | handshake
//   --------+-----------+------------+------------------------
//   in      | input     | in_item_t  | in_valid / in_stall
//   out     | output    | out_item_t | out_valid / out_stall
//
// one item at a time, each walks the record memory through its single read
// port; a refused insert walks nothing; in_stall stays high from acceptance
// until the result is loaded into the output register, longer while the
// result side stalls
// a find may emit up to 32 items, one per matching record
// synchronous reset clears the length; the memory needs no clearing pass
// a result waits in the output register, the next item is taken meanwhile
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_insert_search_tally_core #(
  parameter int CAPACITY = 32
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire alist_pkg::in_item_t in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output alist_pkg::out_item_t out_item
);

  import alist_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_TALLY = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  record_t mem [CAPACITY];
  record_t rd_q_r;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  record_t          wr_data;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [IDX_W-1:0]  addr_r, addr_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic              vld_r, vld_nxt;
  logic [IDX_W-1:0]  vidx_r, vidx_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [NAME_W-1:0] name_r, name_nxt;
  logic [1:0]        cat_r, cat_nxt;
  logic [15:0]       qty_r, qty_nxt;
  logic              hold_v_r, hold_v_nxt;
  logic [4:0]        hold_pos_r, hold_pos_nxt;
  logic [1:0]        hold_cat_r, hold_cat_nxt;
  logic [15:0]       hold_qty_r, hold_qty_nxt;
  logic [5:0]        m_r, m_nxt;
  logic [20:0]       tot0_r, tot0_nxt;
  logic [20:0]       tot1_r, tot1_nxt;
  logic [20:0]       tot2_r, tot2_nxt;
  out_item_t         pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic out_free;
  logic out_load;
  logic match;
  logic consume;
  logic issue;

  function automatic logic [20:0] sat_add(input logic [20:0] a, input logic [15:0] b);
    logic [21:0] s;
    s = {1'b0, a} + {6'd0, b};
    return s[21] ? TOTAL_MAX : s[20:0];
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    state_nxt    = state_r;
    total_nxt    = total_r;
    addr_nxt     = addr_r;
    left_nxt     = left_r;
    vld_nxt      = vld_r;
    vidx_nxt     = vidx_r;
    pos_nxt      = pos_r;
    name_nxt     = name_r;
    cat_nxt      = cat_r;
    qty_nxt      = qty_r;
    hold_v_nxt   = hold_v_r;
    hold_pos_nxt = hold_pos_r;
    hold_cat_nxt = hold_cat_r;
    hold_qty_nxt = hold_qty_r;
    m_nxt        = m_r;
    tot0_nxt     = tot0_r;
    tot1_nxt     = tot1_r;
    tot2_nxt     = tot2_r;
    pend_nxt     = pend_r;
    out_nxt      = out_r;
    out_load     = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = addr_r;
    wr_en        = 1'b0;
    wr_addr      = IDX_W'(32'(vidx_r) + 1);
    wr_data      = rd_q_r;
    issue        = 1'b0;
    consume      = 1'b0;

    out_free = !out_valid_r || !out_stall;
    match    = vld_r && (rd_q_r.name == name_r) && (m_r != RESULT_LIMIT);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          name_nxt   = name_canon({in_item.name_high, in_item.name_mid, in_item.name_low});
          cat_nxt    = in_item.category;
          qty_nxt    = in_item.quantity;
          vld_nxt    = 1'b0;
          hold_v_nxt = 1'b0;
          m_nxt      = '0;
          tot0_nxt   = '0;
          tot1_nxt   = '0;
          tot2_nxt   = '0;
          addr_nxt   = '0;
          left_nxt   = total_r;
          pend_nxt   = '0;
          pend_nxt.last = 1'b1;
          unique case (in_item.kind)
            KIND_INSERT: begin
              if (32'(total_r) >= CAPACITY) begin
                pend_nxt.status = ST_FULL;
                state_nxt       = S_EMIT;
              end else if (32'(in_item.position) > 32'(total_r)) begin
                pend_nxt.status = ST_BAD_POS;
                state_nxt       = S_EMIT;
              end else begin
                addr_nxt  = IDX_W'(32'(total_r) - 1);
                left_nxt  = CNT_W'(32'(total_r) - 32'(in_item.position));
                pos_nxt   = IDX_W'(in_item.position);
                state_nxt = S_SHIFT;
              end
            end
            KIND_FIND:   state_nxt = S_FIND;
            KIND_REPORT: state_nxt = S_TALLY;
            default: ;
          endcase
        end
      end

      S_SHIFT: begin
        // entry read last cycle moves up by one
        if (vld_r) begin
          wr_en = 1'b1;
        end
        if (left_r != '0) begin
          issue    = 1'b1;
          addr_nxt = addr_r - 1'b1;
        end else if (!vld_r) begin
          wr_en            = 1'b1;
          wr_addr          = pos_r;
          wr_data.name     = name_r;
          wr_data.category = cat_r;
          wr_data.quantity = qty_r;
          total_nxt        = total_r + 1'b1;
          pend_nxt.status  = ST_INSERTED;
          state_nxt        = S_EMIT;
        end
      end

      S_FIND: begin
        // a match is held back one step so the final one can carry last
        if (vld_r) begin
          if (match) begin
            if (!hold_v_r || out_free) begin
              consume = 1'b1;
              if (hold_v_r) begin
                out_load               = 1'b1;
                out_nxt                = '0;
                out_nxt.status         = ST_MATCH;
                out_nxt.found_position = hold_pos_r;
                out_nxt.found_category = hold_cat_r;
                out_nxt.found_quantity = hold_qty_r;
              end
              hold_v_nxt   = 1'b1;
              hold_pos_nxt = 5'(vidx_r);
              hold_cat_nxt = rd_q_r.category;
              hold_qty_nxt = rd_q_r.quantity;
              m_nxt        = m_r + 1'b1;
            end
          end else begin
            consume = 1'b1;
          end
        end
        if ((!vld_r || consume) && left_r != '0 && m_r != RESULT_LIMIT) begin
          issue    = 1'b1;
          addr_nxt = addr_r + 1'b1;
        end else if (vld_r && !consume) begin
          vld_nxt = 1'b1;
        end else begin
          vld_nxt = 1'b0;
        end
        if (!vld_r && (left_r == '0 || m_r == RESULT_LIMIT) && out_free) begin
          out_load     = 1'b1;
          out_nxt      = '0;
          out_nxt.last = 1'b1;
          if (hold_v_r) begin
            out_nxt.status         = ST_MATCH;
            out_nxt.found_position = hold_pos_r;
            out_nxt.found_category = hold_cat_r;
            out_nxt.found_quantity = hold_qty_r;
          end else begin
            out_nxt.status = ST_NO_MATCH;
          end
          state_nxt = S_IDLE;
        end
      end

      S_TALLY: begin
        if (vld_r) begin
          unique case (rd_q_r.category)
            CAT_PERENNIAL: tot0_nxt = sat_add(tot0_r, rd_q_r.quantity);
            CAT_ANNUAL:    tot1_nxt = sat_add(tot1_r, rd_q_r.quantity);
            CAT_BIENNIAL:  tot2_nxt = sat_add(tot2_r, rd_q_r.quantity);
            default: ;
          endcase
        end
        if (left_r != '0) begin
          issue    = 1'b1;
          addr_nxt = addr_r + 1'b1;
        end else if (!vld_r) begin
          pend_nxt.status          = ST_TOTALS;
          pend_nxt.total_perennial = tot0_r;
          pend_nxt.total_annual    = tot1_r;
          pend_nxt.total_biennial  = tot2_r;
          state_nxt                = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_nxt   = pend_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (issue) begin
      rd_en    = 1'b1;
      rd_addr  = addr_r;
      left_nxt = left_r - 1'b1;
      vld_nxt  = 1'b1;
      vidx_nxt = addr_r;
    end else if (state_r == S_SHIFT || state_r == S_TALLY) begin
      vld_nxt = 1'b0;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // record memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      vld_r       <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      vld_r       <= vld_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    left_r     <= left_nxt;
    vidx_r     <= vidx_nxt;
    pos_r      <= pos_nxt;
    name_r     <= name_nxt;
    cat_r      <= cat_nxt;
    qty_r      <= qty_nxt;
    hold_pos_r <= hold_pos_nxt;
    hold_cat_r <= hold_cat_nxt;
    hold_qty_r <= hold_qty_nxt;
    m_r        <= m_nxt;
    tot0_r     <= tot0_nxt;
    tot1_r     <= tot1_nxt;
    tot2_r     <= tot2_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
  end

endmodule

`default_nettype wire

/* rtl/core/alist_checker.sv */
// ----------------------------------------------------------------------------
// alist_checker
// port-level checks on the array list core, bound onto the core module
// ----------------------------------------------------------------------------
`default_nettype none

`include "array_list_insert_search_tally_core_defines.svh"

module alist_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_stall,
  input wire alist_pkg::in_item_t  in_item,
  input wire                  out_valid,
  input wire                  out_stall,
  input wire alist_pkg::out_item_t out_item
);

  import alist_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  `ALIST_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `ALIST_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid, "result valid right after reset")
  `ALIST_ASSERT(a_single_last, out_valid && out_item.status != ST_MATCH |-> out_item.last, "single result without last")
  `ALIST_ASSERT(a_totals_clean, out_valid && out_item.status == ST_TOTALS |-> out_item.found_quantity == 16'd0 && out_item.found_position == 5'd0, "totals carry match fields")
  `ALIST_ASSERT(a_busy_after_insert, in_acc && in_item.kind == KIND_INSERT |=> in_stall, "insert accepted without busy")

endmodule

bind array_list_insert_search_tally_core alist_checker u_alist_checker (.*);

`default_nettype wire
